FILE: rtl/iacr_pkg.sv
// Shared constants for the intake anti-jam and color reject block.
// Used by iacr_phase and intake_antijam_color_reject; no dependencies.
package iacr_pkg;

  localparam int NOW_W   = 32;
  localparam int DRIVE_W = 15;
  localparam int CUR_W   = 14;
  localparam int QUO_W   = 24;

  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_DOWN  = 2'd1;
  localparam logic [1:0] MODE_UP    = 2'd2;
  localparam logic [1:0] MODE_AUTON = 2'd3;

  localparam logic [1:0] COLOR_NONE = 2'd0;
  localparam logic [1:0] COLOR_RED  = 2'd1;
  localparam logic [1:0] COLOR_BLUE = 2'd2;

  localparam logic [1:0] SIDE_RED  = 2'd1;
  localparam logic [1:0] SIDE_BLUE = 2'd2;

  localparam logic [1:0] REG_ALLIANCE   = 2'd0;
  localparam logic [1:0] REG_STALL_CUR  = 2'd1;
  localparam logic [1:0] REG_STALL_TIME = 2'd2;
  localparam logic [1:0] REG_PROX_MIN   = 2'd3;

  localparam logic signed [DRIVE_W-1:0] DRIVE_FULL  = 15'sd12000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_AUTON = 15'sd9000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_DOWN  = -15'sd12000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_BACK  = -15'sd6000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_ZERO  = 15'sd0;

  localparam logic [8:0] HUE_RED_LO_MAX = 9'd20;
  localparam logic [8:0] HUE_BLUE_MIN   = 9'd180;
  localparam logic [8:0] HUE_BLUE_MAX   = 9'd240;
  localparam logic [8:0] HUE_RED_HI_MIN = 9'd300;
  localparam logic [8:0] HUE_RED_HI_MAX = 9'd340;

  localparam logic [8:0] PULSE_HALF = 9'd200;
  // ceil(2^33 / 25): exact quotient of a 28-bit value by 25.
  localparam logic [28:0] RECIP_25 = 29'd343597384;

  localparam logic [12:0] RST_STALL_CUR  = 13'd2300;
  localparam logic [9:0]  RST_STALL_TIME = 10'd60;
  localparam logic [7:0]  RST_PROX_MIN   = 8'd100;

endpackage

FILE: rtl/iacr_phase.sv
// Pulse phase of the timestamp: flags now_ms mod 400 above 200.
// The quotient by 400 is registered after a reciprocal multiply; uses iacr_pkg.
module iacr_phase (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [iacr_pkg::NOW_W-1:0] now_s1,
  input  logic [iacr_pkg::NOW_W-1:0] now_s2,
  output logic                      pulse_hi
);
  import iacr_pkg::*;

  logic [56:0]      prod;
  logic [QUO_W-1:0] quo_r;
  logic [QUO_W-1:0] quo_nxt;
  logic [32:0]      back;
  logic [8:0]       rem;

  assign prod    = {29'd0, now_s1[31:4]} * {28'd0, RECIP_25};
  assign quo_nxt = prod[56:33];

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r <= quo_nxt;
    end
  end

  assign back     = {1'b0, quo_r, 8'd0} + {2'b0, quo_r, 7'd0} + {5'd0, quo_r, 4'd0};
  assign rem      = now_s2[8:0] - back[8:0];
  assign pulse_hi = rem > PULSE_HALF;

endmodule

FILE: rtl/intake_antijam_color_reject.sv
// Top level of the intake hook controller with color reject and anti-jam pulsing.
// Depends on iacr_pkg and iacr_phase.
//
// Usage: one sample per transfer on the in_ stream, one result per sample on
// the out_ stream, in order. in_tdata carries now_ms, hook_mode, sort_enable,
// proximity, hue and current_ma; out_tdata carries drive_mv, eject_pause,
// ring_color and led_on.
// One sample is taken every cycle while the pipeline is not held. The pipeline
// is an input register, a stage holding the quotient of now_ms by 400 from the
// reciprocal product, and the result register where the stall timer, color
// state and drive selection are updated.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline holds and in_tready drops; nothing is lost or repeated.
// Configuration is to be written through cfg_ only while idle; this is not
// enforced, as cfg_ready is always high. Reset (rst_n low, synchronous) empties
// the pipeline, clears the stall timer, pulsing flag, last color and last drive,
// and loads the register defaults: side unknown, 2300 mA, 60 ms, proximity 100.
module intake_antijam_color_reject (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], hook_mode[33:32], sort_enable[34], proximity[42:35],
  // hue[51:43], current_ma[65:52], zero fill[71:66]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_mv[14:0], eject_pause[15], ring_color[17:16], led_on[18], zero fill[23:19]
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data
);
  import iacr_pkg::*;

  logic adv;

  logic [1:0]  side_r;
  logic [12:0] stall_cur_r;
  logic [9:0]  stall_time_r;
  logic [7:0]  prox_min_r;

  logic              v1_r, v2_r, out_valid_r;
  logic [65:0]       s1_r;
  logic [65:0]       s2_r;

  logic [NOW_W-1:0]          stall_start_r, stall_start_nxt;
  logic                      pulsing_r, pulsing_nxt;
  logic [1:0]                last_color_r;
  logic signed [DRIVE_W-1:0] last_drive_r, drive_nxt;

  logic [DRIVE_W-1:0] drive_out_r;
  logic               eject_r, eject_nxt;
  logic [1:0]         color_out_r, color_nxt;
  logic               led_r;

  logic [NOW_W-1:0]        now2;
  logic [1:0]              mode2;
  logic                    sort2;
  logic [7:0]              prox2;
  logic [8:0]              hue2;
  logic signed [CUR_W-1:0] cur2;
  logic [CUR_W-1:0]        mag;
  logic [NOW_W-1:0]        elapsed;
  logic                    pulse_hi;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= 2'd0;
      stall_cur_r  <= RST_STALL_CUR;
      stall_time_r <= RST_STALL_TIME;
      prox_min_r   <= RST_PROX_MIN;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_ALLIANCE:   side_r       <= cfg_data[1:0];
        REG_STALL_CUR:  stall_cur_r  <= cfg_data;
        REG_STALL_TIME: stall_time_r <= cfg_data[9:0];
        REG_PROX_MIN:   prox_min_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_tdata[65:0];
      s2_r <= s1_r;
    end
  end

  iacr_phase u_phase (
    .clk      (clk),
    .adv      (adv),
    .now_s1   (s1_r[31:0]),
    .now_s2   (s2_r[31:0]),
    .pulse_hi (pulse_hi)
  );

  assign now2  = s2_r[31:0];
  assign mode2 = s2_r[33:32];
  assign sort2 = s2_r[34];
  assign prox2 = s2_r[42:35];
  assign hue2  = s2_r[51:43];
  assign cur2  = s2_r[65:52];

  assign mag     = cur2[CUR_W-1] ? (~cur2 + 14'sd1) : cur2;
  assign elapsed = now2 - stall_start_r;

  always_comb begin
    color_nxt = COLOR_NONE;
    if (prox2 >= prox_min_r) begin
      if (hue2 <= HUE_RED_LO_MAX) begin
        color_nxt = COLOR_RED;
      end else if (hue2 >= HUE_BLUE_MIN && hue2 <= HUE_BLUE_MAX) begin
        color_nxt = COLOR_BLUE;
      end else if (hue2 >= HUE_RED_HI_MIN && hue2 <= HUE_RED_HI_MAX) begin
        color_nxt = COLOR_RED;
      end
    end
  end

  always_comb begin
    drive_nxt       = last_drive_r;
    stall_start_nxt = stall_start_r;
    pulsing_nxt     = pulsing_r;
    eject_nxt       = 1'b0;
    if (mode2 == MODE_STOP || mode2 == MODE_DOWN) begin
      drive_nxt       = (mode2 == MODE_STOP) ? DRIVE_ZERO : DRIVE_DOWN;
      stall_start_nxt = '0;
      pulsing_nxt     = 1'b0;
    end else if (mag > {1'b0, stall_cur_r}) begin
      if (stall_start_r == '0) begin
        stall_start_nxt = now2;
      end else if (elapsed > {22'd0, stall_time_r}) begin
        if (!pulsing_r) begin
          pulsing_nxt = 1'b1;
          drive_nxt   = DRIVE_FULL;
        end else begin
          drive_nxt = pulse_hi ? DRIVE_FULL : DRIVE_BACK;
        end
      end
    end else begin
      stall_start_nxt = '0;
      pulsing_nxt     = 1'b0;
      if (!sort2) begin
        drive_nxt = DRIVE_FULL;
      end else begin
        drive_nxt = (mode2 == MODE_AUTON) ? DRIVE_AUTON : DRIVE_FULL;
        eject_nxt = (side_r == SIDE_RED && last_color_r == COLOR_BLUE) ||
                    (side_r == SIDE_BLUE && last_color_r == COLOR_RED);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_start_r <= '0;
      pulsing_r     <= 1'b0;
      last_color_r  <= COLOR_NONE;
      last_drive_r  <= DRIVE_ZERO;
    end else if (adv && v2_r) begin
      stall_start_r <= stall_start_nxt;
      pulsing_r     <= pulsing_nxt;
      last_color_r  <= color_nxt;
      last_drive_r  <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      drive_out_r <= drive_nxt;
      eject_r     <= eject_nxt;
      color_out_r <= color_nxt;
      led_r       <= sort2;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, led_r, color_out_r, eject_r, drive_out_r};

  a_eject_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && eject_r) |->
      ($signed(drive_out_r) == DRIVE_FULL || $signed(drive_out_r) == DRIVE_AUTON))
    else $error("eject pause raised with a drive other than forward");

  a_pulse_timer: assert property (@(posedge clk) disable iff (!rst_n)
    pulsing_r |-> (stall_start_r != '0))
    else $error("pulsing without a running stall timer");

  a_color_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (color_out_r != 2'd3 && last_color_r != 2'd3))
    else $error("invalid ring color code");

endmodule
